### hw/rtl/bounded_indexed_list_engine_macros.svh
// assertion helpers for the list engine, sampled on clk and held off during reset
`ifndef BOUNDED_INDEXED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_INDEXED_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define BIL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BIL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bil_pkg.sv
package bil_pkg;

    localparam int OP_W   = 4;
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT       = 4'd0,
        OP_INSERT_FRONT = 4'd1,
        OP_INSERT_BACK  = 4'd2,
        OP_REMOVE       = 4'd3,
        OP_REMOVE_FRONT = 4'd4,
        OP_REMOVE_BACK  = 4'd5,
        OP_REPLACE      = 4'd6,
        OP_SELECT       = 4'd7,
        OP_SEARCH       = 4'd8
    } op_t;

    // what every cell of the chain does
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_REPLACE,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

endpackage

### hw/rtl/bil_req_if.sv
interface bil_req_if;
    logic                        valid;
    logic                        ready;
    logic [bil_pkg::OP_W-1:0]    opcode;
    logic [bil_pkg::POS_W-1:0]   position;
    logic [bil_pkg::DATA_W-1:0]  item_value;

    modport source (output valid, output opcode, output position, output item_value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input item_value,
                    output ready);
endinterface

### hw/rtl/bil_rsp_if.sv
interface bil_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic [bil_pkg::DATA_W-1:0]  read_value;
    logic [bil_pkg::POS_W-1:0]   found_position;
    logic [bil_pkg::POS_W-1:0]   entry_count;
    logic                        is_empty;
    logic                        is_full;

    modport source (output valid, output ok, output read_value, output found_position,
                    output entry_count, output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input read_value, input found_position,
                    input entry_count, input is_empty, input is_full, output ready);
endinterface

### hw/rtl/bounded_indexed_list_engine.sv
// Ordered list of up to CAPACITY_MAX values held in a row of cells, entry 0 in
// cell 0. One request beat carries an opcode, a position and a value; every
// request gives exactly one response beat with ok, the read value, the found
// position, the entry count after the operation and the empty/full flags.
// Insert, remove and replace (and any opcode that fails or does nothing) are
// done in the accept cycle: insert and remove shift the cells from the position
// on, replace writes one cell, and the response is registered the next cycle:
// one request per cycle as long as the response side keeps up. Select and
// search rotate the chain one entry per cycle through cell 0, where the single
// comparator looks at it, and once every entry has passed through it the list
// is back in order. Requests are held off while a rotation runs. The cell
// contents are not cleared at reset; only entries below the count are ever read.
module bounded_indexed_list_engine #(
    parameter int CAPACITY_MAX = 16,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    bil_req_if.sink       req,
    bil_rsp_if.source     rsp
);

`include "bounded_indexed_list_engine_macros.svh"

    // count width holds CAPACITY_MAX itself; position compares need at least 5 bits
    localparam int CW = $clog2(CAPACITY_MAX + 1);
    localparam int PW = (CW > bil_pkg::POS_W) ? CW : bil_pkg::POS_W;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY_MAX);

    // control state
    bil_pkg::state_t state_reg;
    bil_pkg::state_t state_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   step_reg;
    logic [CW-1:0]   step_next;
    logic            hit_reg;
    logic            hit_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    // scan payload
    logic                   scan_sel_reg;
    logic                   scan_sel_next;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [VALUE_WIDTH-1:0] key_next;
    logic [CW-1:0]          tgt_reg;
    logic [CW-1:0]          tgt_next;
    logic [CW-1:0]          found_reg;
    logic [CW-1:0]          found_next;
    logic [VALUE_WIDTH-1:0] rdv_reg;
    logic [VALUE_WIDTH-1:0] rdv_next;

    // response register
    logic                          ok_o_reg;
    logic                          ok_o_next;
    logic [bil_pkg::DATA_W-1:0]    read_o_reg;
    logic [bil_pkg::DATA_W-1:0]    read_o_next;
    logic [bil_pkg::POS_W-1:0]     found_o_reg;
    logic [bil_pkg::POS_W-1:0]     found_o_next;
    logic [bil_pkg::POS_W-1:0]     cnt_o_reg;
    logic [bil_pkg::POS_W-1:0]     cnt_o_next;
    logic                          empty_o_reg;
    logic                          empty_o_next;
    logic                          full_o_reg;
    logic                          full_o_next;

    // handshake and decode
    logic                   out_free;
    logic                   req_ready;
    logic                   accept;
    logic                   load_drain;
    bil_pkg::op_t           op;
    logic [PW-1:0]          pos_w;
    logic [PW-1:0]          cnt_w;
    logic [VALUE_WIDTH-1:0] val_in;
    logic                   not_full;
    logic                   start_scan;
    logic                   imm_ok;
    logic [CW-1:0]          cnt_after;
    bil_pkg::cell_op_t      dec_op;
    logic [PW-1:0]          dec_pos;
    bil_pkg::cell_op_t      cell_op;
    logic                   last_step;

    // the chain
    logic [VALUE_WIDTH-1:0] cell_data [CAPACITY_MAX];
    logic [VALUE_WIDTH-1:0] head;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req_ready;
    assign op        = bil_pkg::op_t'(req.opcode);
    assign pos_w     = PW'(req.position);
    assign cnt_w     = PW'(count_reg);
    assign val_in    = VALUE_WIDTH'(req.item_value);
    assign not_full  = (count_reg != CAP);
    assign head      = cell_data[0];
    assign last_step = (step_reg == (count_reg - CW'(1)));

    // request decode: what the cells do and what the response says
    always_comb
    begin
        dec_op     = bil_pkg::CELL_HOLD;
        dec_pos    = pos_w;
        imm_ok     = 1'b0;
        start_scan = 1'b0;
        cnt_after  = count_reg;
        case (op)
            bil_pkg::OP_INSERT:
            begin
                if (not_full && (pos_w <= cnt_w))
                begin
                    dec_op = bil_pkg::CELL_INSERT;
                    imm_ok = 1'b1;
                end
            end
            bil_pkg::OP_INSERT_FRONT:
            begin
                dec_pos = '0;
                if (not_full)
                begin
                    dec_op = bil_pkg::CELL_INSERT;
                    imm_ok = 1'b1;
                end
            end
            bil_pkg::OP_INSERT_BACK:
            begin
                dec_pos = cnt_w;
                if (not_full)
                begin
                    dec_op = bil_pkg::CELL_INSERT;
                    imm_ok = 1'b1;
                end
            end
            bil_pkg::OP_REMOVE:
            begin
                if (pos_w < cnt_w)
                begin
                    dec_op = bil_pkg::CELL_REMOVE;
                    imm_ok = 1'b1;
                end
            end
            bil_pkg::OP_REMOVE_FRONT:
            begin
                dec_pos = '0;
                if (count_reg != '0)
                begin
                    dec_op = bil_pkg::CELL_REMOVE;
                    imm_ok = 1'b1;
                end
            end
            bil_pkg::OP_REMOVE_BACK:
            begin
                dec_pos = cnt_w - PW'(1);
                if (count_reg != '0)
                begin
                    dec_op = bil_pkg::CELL_REMOVE;
                    imm_ok = 1'b1;
                end
            end
            bil_pkg::OP_REPLACE:
            begin
                if (pos_w < cnt_w)
                begin
                    dec_op = bil_pkg::CELL_REPLACE;
                    imm_ok = 1'b1;
                end
            end
            bil_pkg::OP_SELECT, bil_pkg::OP_SEARCH:
            begin
                // an empty list answers at once with ok low
                start_scan = (count_reg != '0);
            end
            default:
            begin
                dec_op = bil_pkg::CELL_HOLD;
            end
        endcase
        if (dec_op == bil_pkg::CELL_INSERT)
        begin
            cnt_after = count_reg + CW'(1);
        end
        else if (dec_op == bil_pkg::CELL_REMOVE)
        begin
            cnt_after = count_reg - CW'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bil_pkg::ST_IDLE:
            begin
                if (accept && start_scan)
                begin
                    state_next = bil_pkg::ST_SCAN;
                end
            end
            bil_pkg::ST_SCAN:
            begin
                if (last_step)
                begin
                    state_next = bil_pkg::ST_DRAIN;
                end
            end
            bil_pkg::ST_DRAIN:
            begin
                if (out_free)
                begin
                    state_next = bil_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bil_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req_ready  = 1'b0;
        load_drain = 1'b0;
        cell_op    = bil_pkg::CELL_HOLD;
        case (state_reg)
            bil_pkg::ST_IDLE:
            begin
                req_ready = out_free;
                cell_op   = (req.valid && out_free) ? dec_op : bil_pkg::CELL_HOLD;
            end
            bil_pkg::ST_SCAN:
            begin
                cell_op = bil_pkg::CELL_ROTATE;
            end
            bil_pkg::ST_DRAIN:
            begin
                load_drain = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign req.ready = req_ready;

    // scan datapath: cell 0 holds original entry step_reg at each scan cycle
    always_comb
    begin
        count_next    = count_reg;
        step_next     = step_reg;
        hit_next      = hit_reg;
        scan_sel_next = scan_sel_reg;
        key_next      = key_reg;
        tgt_next      = tgt_reg;
        found_next    = found_reg;
        rdv_next      = rdv_reg;
        if (accept)
        begin
            count_next = cnt_after;
            if (start_scan)
            begin
                step_next     = '0;
                hit_next      = 1'b0;
                scan_sel_next = (op == bil_pkg::OP_SELECT);
                key_next      = val_in;
                // select past the end reads the last entry
                tgt_next      = (pos_w < cnt_w) ? CW'(pos_w) : (count_reg - CW'(1));
                found_next    = count_reg;
                rdv_next      = '0;
            end
        end
        else if (state_reg == bil_pkg::ST_SCAN)
        begin
            step_next = step_reg + CW'(1);
            if (scan_sel_reg)
            begin
                if (step_reg == tgt_reg)
                begin
                    rdv_next = head;
                end
            end
            else if (!hit_reg && (head == key_reg))
            begin
                hit_next   = 1'b1;
                found_next = step_reg;
            end
        end
    end

    // response register, loaded straight from decode or at the end of a scan
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        ok_o_next      = ok_o_reg;
        read_o_next    = read_o_reg;
        found_o_next   = found_o_reg;
        cnt_o_next     = cnt_o_reg;
        empty_o_next   = empty_o_reg;
        full_o_next    = full_o_reg;
        if (accept && !start_scan)
        begin
            out_valid_next = 1'b1;
            ok_o_next      = imm_ok;
            read_o_next    = '0;
            found_o_next   = bil_pkg::POS_W'(cnt_after);
            cnt_o_next     = bil_pkg::POS_W'(cnt_after);
            empty_o_next   = (cnt_after == '0);
            full_o_next    = (cnt_after == CAP);
        end
        else if (load_drain)
        begin
            out_valid_next = 1'b1;
            ok_o_next      = scan_sel_reg || hit_reg;
            read_o_next    = bil_pkg::DATA_W'(rdv_reg);
            found_o_next   = bil_pkg::POS_W'(found_reg);
            cnt_o_next     = bil_pkg::POS_W'(count_reg);
            empty_o_next   = (count_reg == '0);
            full_o_next    = (count_reg == CAP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bil_pkg::ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_sel_reg <= scan_sel_next;
        key_reg      <= key_next;
        tgt_reg      <= tgt_next;
        found_reg    <= found_next;
        rdv_reg      <= rdv_next;
        ok_o_reg     <= ok_o_next;
        read_o_reg   <= read_o_next;
        found_o_reg  <= found_o_next;
        cnt_o_reg    <= cnt_o_next;
        empty_o_reg  <= empty_o_next;
        full_o_reg   <= full_o_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = ok_o_reg;
    assign rsp.read_value     = read_o_reg;
    assign rsp.found_position = found_o_reg;
    assign rsp.entry_count    = cnt_o_reg;
    assign rsp.is_empty       = empty_o_reg;
    assign rsp.is_full        = full_o_reg;

    // row of cells: left neighbor feeds inserts, right neighbor feeds removes and rotation
    for (genvar g = 0; g < CAPACITY_MAX; g++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_value;
        logic [VALUE_WIDTH-1:0] right_value;

        if (g == 0)
        begin : g_first
            assign left_value = val_in;
        end
        else
        begin : g_mid_l
            assign left_value = cell_data[g-1];
        end

        if (g == CAPACITY_MAX - 1)
        begin : g_last
            assign right_value = cell_data[g];
        end
        else
        begin : g_mid_r
            assign right_value = cell_data[g+1];
        end

        bil_cell #(
            .INDEX (g),
            .VW    (VALUE_WIDTH),
            .PW    (PW)
        ) u_cell (
            .clk         (clk),
            .op          (cell_op),
            .pos         (dec_pos),
            .count       (cnt_w),
            .new_value   (val_in),
            .left_value  (left_value),
            .right_value (right_value),
            .head_value  (head),
            .data        (cell_data[g])
        );
    end

    // checks
    `BIL_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CAP, "entry count above capacity")
    `BIL_ASSERT_IMP(a_scan_step, state_reg == bil_pkg::ST_SCAN, step_reg < count_reg,
                    "scan step ran past the count")
    `BIL_ASSERT_NXT(a_count_hold, !accept, $stable(count_reg), "count moved without a beat")
    `BIL_ASSERT_IMP(a_busy_block, state_reg != bil_pkg::ST_IDLE, !req_ready,
                    "request taken during a scan")

endmodule

### hw/rtl/bil_cell.sv
module bil_cell #(
    parameter int INDEX = 0,
    parameter int VW    = 32,
    parameter int PW    = 5
) (
    input  logic                      clk,
    input  bil_pkg::cell_op_t         op,
    input  logic [PW-1:0]             pos,
    input  logic [PW-1:0]             count,
    input  logic [VW-1:0]             new_value,
    input  logic [VW-1:0]             left_value,
    input  logic [VW-1:0]             right_value,
    input  logic [VW-1:0]             head_value,
    output logic [VW-1:0]             data
);

    localparam logic [PW-1:0] MY_IDX   = PW'(INDEX);
    localparam logic [PW-1:0] NEXT_IDX = PW'(INDEX + 1);

    logic [VW-1:0] data_reg;
    logic [VW-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            bil_pkg::CELL_INSERT:
            begin
                if (MY_IDX == pos)
                begin
                    data_next = new_value;
                end
                else if (MY_IDX > pos)
                begin
                    data_next = left_value;
                end
            end
            bil_pkg::CELL_REMOVE:
            begin
                if (MY_IDX >= pos)
                begin
                    data_next = right_value;
                end
            end
            bil_pkg::CELL_REPLACE:
            begin
                if (MY_IDX == pos)
                begin
                    data_next = new_value;
                end
            end
            bil_pkg::CELL_ROTATE:
            begin
                // last live cell wraps around to the head
                if (MY_IDX < count)
                begin
                    data_next = (NEXT_IDX == count) ? head_value : right_value;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
